FILE: src/bscs_pkg.sv
// Shared constants, types and a helper function for the bright spot centroid steering block
`default_nettype none
package bscs_pkg;

  // Coordinate and count widths
  localparam int COORD_BITS = 12;
  localparam int COUNT_BITS = 24;
  localparam int SUM_BITS   = COORD_BITS + COUNT_BITS;
  localparam int STEP_BITS  = $clog2(COORD_BITS);

  // Field widths
  localparam int PIXEL_BITS = 8;
  localparam int THR_BITS   = 8;
  localparam int FW_BITS    = 13;
  localparam int DIR_BITS   = 2;
  localparam int OUT_COORD_BITS = 12;

  // Configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 1'd1;
  localparam logic [THR_BITS-1:0] THR_RESET = 8'd253;
  localparam logic [FW_BITS-1:0]  FW_RESET  = 13'd640;

  // Direction codes
  localparam logic [DIR_BITS-1:0] DIR_STOP  = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_LEFT  = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_RIGHT = 2'd2;
  localparam logic [DIR_BITS-1:0] DIR_FWD   = 2'd3;

  // Reciprocal of three for the width thirds, exact for widths up to 2^COORD_BITS
  localparam int RECIP_SHIFT = COORD_BITS + 2;
  localparam int RECIP3      = ((1 << RECIP_SHIFT) + 2) / 3;
  localparam int PROD_BITS   = COORD_BITS + 1 + RECIP_SHIFT;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic start_div;
    logic step_div;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // Clamp the programmed width to 1 .. 2^COORD_BITS
  function automatic logic [COORD_BITS:0] eff_width(input logic [FW_BITS-1:0] fw);
    logic [COORD_BITS:0] w;
    if (fw == '0) begin
      w = (COORD_BITS+1)'(1);
    end else if (int'(fw) > (1 << COORD_BITS)) begin
      w = (COORD_BITS+1)'(1 << COORD_BITS);
    end else begin
      w = (COORD_BITS+1)'(fw);
    end
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: src/bscs_pix_if.sv
// Pixel input channel: valid, ready and one pixel beat
`default_nettype none
interface bscs_pix_if;
  logic                                valid;
  logic                                ready;
  logic [bscs_pkg::PIXEL_BITS-1:0]     pixel;
  logic                                end_of_frame;

  modport source (output valid, output pixel, output end_of_frame, input ready);
  modport sink   (input valid, input pixel, input end_of_frame, output ready);
endinterface
`default_nettype wire

FILE: src/bscs_res_if.sv
// Result output channel: valid, ready and one steering result beat
`default_nettype none
interface bscs_res_if;
  logic                                  valid;
  logic                                  ready;
  logic [bscs_pkg::DIR_BITS-1:0]         direction;
  logic [bscs_pkg::OUT_COORD_BITS-1:0]   centroid_col;
  logic [bscs_pkg::OUT_COORD_BITS-1:0]   centroid_row;
  logic                                  spot_found;

  modport source (output valid, output direction, output centroid_col,
                  output centroid_row, output spot_found, input ready);
  modport sink   (input valid, input direction, input centroid_col,
                  input centroid_row, input spot_found, output ready);
endinterface
`default_nettype wire

FILE: src/bscs_ctrl.sv
// Controller: pixel handshake and sequencing of the end of frame division
`default_nettype none
module bscs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pix_valid,
  input  wire logic              pix_eof,
  output logic                   pix_ready,
  input  wire bscs_pkg::dp_sts_t sts,
  output bscs_pkg::dp_cmd_t      cmd
);

  bscs_pkg::state_t               state, state_next;
  logic [bscs_pkg::STEP_BITS-1:0] step, step_next;
  logic                           last_step;

  assign last_step = (step == bscs_pkg::STEP_BITS'(bscs_pkg::COORD_BITS - 1));

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bscs_pkg::ST_RUN;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    step_next     = step;
    pix_ready     = 1'b0;
    cmd           = '0;
    unique case (state)
      bscs_pkg::ST_RUN: begin
        pix_ready  = 1'b1;
        cmd.accept = pix_valid;
        if (pix_valid && pix_eof) begin
          cmd.start_div = 1'b1;
          step_next     = '0;
          state_next    = bscs_pkg::ST_DIV;
        end
      end
      bscs_pkg::ST_DIV: begin
        cmd.step_div = 1'b1;
        step_next    = step + 1'b1;
        if (last_step) begin
          state_next = bscs_pkg::ST_FIN;
        end
      end
      bscs_pkg::ST_FIN: begin
        // hold the result until the output register is free
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = bscs_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = bscs_pkg::ST_RUN;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/bscs_dp.sv
// Datapath: raster position, bright pixel sums, shift-subtract dividers and result register
`default_nettype none
module bscs_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [bscs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [bscs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  wire logic [bscs_pkg::PIXEL_BITS-1:0]      pixel,
  input  wire bscs_pkg::dp_cmd_t                    cmd,
  output bscs_pkg::dp_sts_t                         sts,
  input  wire logic                                 res_ready,
  output logic                                      res_valid,
  output logic [bscs_pkg::DIR_BITS-1:0]             direction,
  output logic [bscs_pkg::OUT_COORD_BITS-1:0]       centroid_col,
  output logic [bscs_pkg::OUT_COORD_BITS-1:0]       centroid_row,
  output logic                                      spot_found
);

  localparam int CB = bscs_pkg::COORD_BITS;
  localparam int SB = bscs_pkg::SUM_BITS;
  localparam int NB = bscs_pkg::COUNT_BITS;
  localparam int RS = bscs_pkg::RECIP_SHIFT;
  localparam int PB = bscs_pkg::PROD_BITS;

  logic [bscs_pkg::THR_BITS-1:0] thr;
  logic [bscs_pkg::FW_BITS-1:0]  fw;
  logic [CB:0]                   w;

  logic [CB-1:0] col, row;
  logic [SB-1:0] sum_c, sum_r;
  logic [NB-1:0] cnt;

  logic          bright;
  logic [SB-1:0] sum_c_acc, sum_r_acc;
  logic [NB-1:0] cnt_acc;

  logic [SB-1:0] rem_c, rem_r, dvs;
  logic [CB-1:0] q_c, q_r;
  logic          found;
  logic [CB-1:0] third;
  logic [CB:0]   right_lim;
  logic [PB-1:0] prod;
  logic [SB:0]   diff_c, diff_r;

  logic [bscs_pkg::DIR_BITS-1:0] dir_sel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= bscs_pkg::THR_RESET;
      fw  <= bscs_pkg::FW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bscs_pkg::REG_THRESHOLD: thr <= cfg_wdata[bscs_pkg::THR_BITS-1:0];
        bscs_pkg::REG_WIDTH:     fw  <= cfg_wdata[bscs_pkg::FW_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign w = bscs_pkg::eff_width(fw);

  // Accumulate the current pixel if bright and the count has room
  assign bright    = (pixel > thr) && (cnt != bscs_pkg::COUNT_MAX);
  assign sum_c_acc = bright ? sum_c + SB'(col) : sum_c;
  assign sum_r_acc = bright ? sum_r + SB'(row) : sum_r;
  assign cnt_acc   = bright ? cnt + 1'b1 : cnt;

  // Raster position and sums; clear at end of frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      sum_c <= '0;
      sum_r <= '0;
      cnt   <= '0;
    end else if (cmd.accept) begin
      if (cmd.start_div) begin
        col   <= '0;
        row   <= '0;
        sum_c <= '0;
        sum_r <= '0;
        cnt   <= '0;
      end else begin
        sum_c <= sum_c_acc;
        sum_r <= sum_r_acc;
        cnt   <= cnt_acc;
        if ({1'b0, col} >= w - 1'b1) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  // Width third by multiplication with the reciprocal of three
  assign prod = PB'(w) * PB'(bscs_pkg::RECIP3);

  // Restoring division, one quotient bit per cycle for both coordinates
  assign diff_c = {1'b0, rem_c} - {1'b0, dvs};
  assign diff_r = {1'b0, rem_r} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      rem_c     <= sum_c_acc;
      rem_r     <= sum_r_acc;
      dvs       <= SB'(cnt_acc) << (CB - 1);
      found     <= (cnt_acc != '0);
      third     <= prod[RS+CB-1:RS];
      right_lim <= w - (CB+1)'(prod[RS+CB-1:RS]);
      q_c       <= '0;
      q_r       <= '0;
    end else if (cmd.step_div) begin
      if (!diff_c[SB]) begin
        rem_c <= diff_c[SB-1:0];
      end
      if (!diff_r[SB]) begin
        rem_r <= diff_r[SB-1:0];
      end
      q_c <= {q_c[CB-2:0], ~diff_c[SB]};
      q_r <= {q_r[CB-2:0], ~diff_r[SB]};
      dvs <= dvs >> 1;
    end
  end

  // Classify the centroid column into thirds of the width
  always_comb begin
    if (!found) begin
      dir_sel = bscs_pkg::DIR_STOP;
    end else if (q_c < third) begin
      dir_sel = bscs_pkg::DIR_LEFT;
    end else if ({1'b0, q_c} > right_lim) begin
      dir_sel = bscs_pkg::DIR_RIGHT;
    end else begin
      dir_sel = bscs_pkg::DIR_FWD;
    end
  end

  // Result register: drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      direction    <= dir_sel;
      centroid_col <= found ? bscs_pkg::OUT_COORD_BITS'(q_c) : '0;
      centroid_row <= found ? bscs_pkg::OUT_COORD_BITS'(q_r) : '0;
      spot_found   <= found;
    end
  end

  assign sts.out_free = !res_valid || res_ready;

endmodule
`default_nettype wire

FILE: src/bright_spot_centroid_steer.sv
// Bright spot centroid: one pixel per cycle within a frame. The end of frame pixel
// starts a shift-subtract division (one quotient bit per cycle, COORD_BITS bits);
// the result beat is loaded after the last quotient bit and intake resumes then, so
// no pixel is taken during the division. An untaken result beat stalls intake
// after the next frame's division until it is taken. Synchronous reset clears
// position, sums, count and state, and loads threshold 253 and width 640.
`default_nettype none
module bright_spot_centroid_steer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [bscs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [bscs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  bscs_pix_if.sink                                  pix,
  bscs_res_if.source                                res
);

  bscs_pkg::dp_cmd_t cmd;
  bscs_pkg::dp_sts_t sts;

  bscs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix.valid),
    .pix_eof   (pix.end_of_frame),
    .pix_ready (pix.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bscs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .pixel        (pix.pixel),
    .cmd          (cmd),
    .sts          (sts),
    .res_ready    (res.ready),
    .res_valid    (res.valid),
    .direction    (res.direction),
    .centroid_col (res.centroid_col),
    .centroid_row (res.centroid_row),
    .spot_found   (res.spot_found)
  );

endmodule
`default_nettype wire

FILE: bench/bscs_steer_checker.sv
`timescale 1ns / 100ps
// Steering result checker: follows the pixel and result channels, predicts and compares beats
module bscs_steer_checker
  import bscs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  bscs_pix_if                           pix,
  bscs_res_if                           res,
  output int                            fail_count,
  output int                            pending_count
);

  typedef struct packed {
    logic [DIR_BITS-1:0]       direction;
    logic [OUT_COORD_BITS-1:0] col;
    logic [OUT_COORD_BITS-1:0] row;
    logic                      found;
  } steer_t;

  // Predicted results in frame order, oldest first
  steer_t expected_steer[$];

  // Mirror of the block's registers and frame accumulators
  logic [THR_BITS-1:0]   threshold;
  logic [FW_BITS-1:0]    width_reg;
  logic [COORD_BITS-1:0] col_pos;
  logic [COORD_BITS-1:0] row_pos;
  logic [SUM_BITS-1:0]   col_sum;
  logic [SUM_BITS-1:0]   row_sum;
  logic [COUNT_BITS-1:0] spot_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] steer check: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // Accumulate one pixel beat; on the frame's last pixel queue its centroid and steer
  task automatic track_pixel(input logic [PIXEL_BITS-1:0] p, input logic eof);
    int     w;
    int     third;
    steer_t s;
    w = (width_reg == '0) ? 1 :
        (int'(width_reg) > (1 << COORD_BITS)) ? (1 << COORD_BITS) : int'(width_reg);
    if (p > threshold && spot_count != COUNT_MAX) begin
      col_sum    += SUM_BITS'(col_pos);
      row_sum    += SUM_BITS'(row_pos);
      spot_count += 1'b1;
    end
    if (!eof) begin
      // wrap also when a narrower width left the column already past the edge
      if (int'(col_pos) >= w - 1) begin
        col_pos = '0;
        row_pos += 1'b1;
      end else begin
        col_pos += 1'b1;
      end
    end else begin
      s = '0;
      s.direction = DIR_STOP;
      if (spot_count != '0) begin
        third = w / 3;
        s.col   = OUT_COORD_BITS'(col_sum / SUM_BITS'(spot_count));
        s.row   = OUT_COORD_BITS'(row_sum / SUM_BITS'(spot_count));
        s.found = 1'b1;
        // both boundary columns count as forward
        if (int'(s.col) < third) begin
          s.direction = DIR_LEFT;
        end else if (int'(s.col) > w - third) begin
          s.direction = DIR_RIGHT;
        end else begin
          s.direction = DIR_FWD;
        end
      end
      expected_steer = {expected_steer, s};
      col_pos    = '0;
      row_pos    = '0;
      col_sum    = '0;
      row_sum    = '0;
      spot_count = '0;
    end
  endtask

  always @(posedge clk) begin
    steer_t got;
    steer_t want;
    if (rst) begin
      threshold  = THR_RESET;
      width_reg  = FW_RESET;
      col_pos    = '0;
      row_pos    = '0;
      col_sum    = '0;
      row_sum    = '0;
      spot_count = '0;
      expected_steer.delete();
    end else begin
      // compare a result beat against the oldest prediction
      if (res.valid && res.ready) begin
        got = '{res.direction, res.centroid_col, res.centroid_row, res.spot_found};
        if (expected_steer.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: dir %0d col %0d row %0d",
                                    got.direction, got.col, got.row));
        end else begin
          want = expected_steer.pop_front();
          check_field("direction", got.direction, want.direction);
          check_field("centroid_col", got.col, want.col);
          check_field("centroid_row", got.row, want.row);
          check_field("spot_found", got.found, want.found);
        end
      end
      // track register writes
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) begin
          threshold = cfg_wdata[THR_BITS-1:0];
        end else if (cfg_index == REG_WIDTH) begin
          width_reg = cfg_wdata[FW_BITS-1:0];
        end
      end
      if (pix.valid && pix.ready) begin
        track_pixel(pix.pixel, pix.end_of_frame);
      end
    end
    pending_count <= expected_steer.size();
  end

endmodule

FILE: bench/bright_spot_centroid_steer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the steering block: clock, reset, register writes, pixel frames, verdict
module bright_spot_centroid_steer_tb;
  import bscs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_PIXELS = 1700;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;
  int fail_count;
  int pending_count;

  bscs_pix_if pix ();
  bscs_res_if res ();

  bright_spot_centroid_steer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pix       (pix),
    .res       (res)
  );

  bscs_steer_checker steer_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .pix           (pix),
    .res           (res),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL bright_spot_centroid_steer");
      $finish;
    end
  end

  // Offer one pixel beat, idling first at random, and hold it until taken
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] p, input logic eof);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid        <= 1'b1;
    pix.pixel        <= p;
    pix.end_of_frame <= eof;
    do @(posedge clk); while (!pix.ready);
  endtask

  // Drop valid and wait until every pending result has drained and the divider is quiet
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_BITS'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int sent;
    int len;
    logic [PIXEL_BITS-1:0] p;
    pix.valid        = 1'b0;
    pix.pixel        = '0;
    pix.end_of_frame = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_THRESHOLD;
    cfg_wdata        = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: 254 and 255 are bright, 253 is not
    send_pixel(8'd254, 1'b0);
    send_pixel(8'd253, 1'b0);
    send_pixel(8'd255, 1'b1);
    // one-pixel frame with nothing bright: stop
    send_pixel(8'd0, 1'b1);

    // width zero acts as one column, so every pixel starts a new row
    settle();
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_WIDTH, 0);
    send_pixel(8'd1, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd1, 1'b1);

    // top threshold: even full scale is dark
    settle();
    write_reg(REG_THRESHOLD, 255);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b1);

    // width beyond the coordinate range clamps
    settle();
    write_reg(REG_THRESHOLD, 100);
    write_reg(REG_WIDTH, 8191);
    send_pixel(8'd101, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd200, 1'b1);

    // centroid exactly on the left third boundary goes forward
    settle();
    write_reg(REG_WIDTH, 9);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);

    // narrow the width mid-frame while the column is already past the new edge
    settle();
    write_reg(REG_WIDTH, 8);
    for (int i = 0; i < 5; i++) send_pixel(8'd0, 1'b0);
    send_pixel(8'd200, 1'b0);
    settle();
    write_reg(REG_WIDTH, 4);
    send_pixel(8'd200, 1'b0);
    send_pixel(8'd200, 1'b1);

    // Random frames under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 14 : 0;
      sent = 0;
      while (sent < RANDOM_PIXELS / 3) begin
        // new settings now and then, only once the block has gone quiet
        if ($urandom_range(0, 3) == 0) begin
          settle();
          case ($urandom_range(0, 7))
            0:       write_reg(REG_THRESHOLD, 0);
            1:       write_reg(REG_THRESHOLD, 255);
            default: write_reg(REG_THRESHOLD, $urandom_range(0, 255));
          endcase
          case ($urandom_range(0, 15))
            0:       write_reg(REG_WIDTH, 0);
            1:       write_reg(REG_WIDTH, 1);
            2:       write_reg(REG_WIDTH, 4096);
            3:       write_reg(REG_WIDTH, $urandom_range(4097, 8191));
            4:       write_reg(REG_WIDTH, $urandom_range(17, 300));
            default: write_reg(REG_WIDTH, $urandom_range(2, 16));
          endcase
        end
        case ($urandom_range(0, 9))
          0:       len = 1;
          1:       len = $urandom_range(41, 150);
          default: len = $urandom_range(2, 24);
        endcase
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 9))
            0:       p = 8'd0;
            1:       p = 8'd255;
            default: p = PIXEL_BITS'($urandom_range(0, 255));
          endcase
          send_pixel(p, i == len - 1);
        end
        sent += len;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS bright_spot_centroid_steer");
    end else begin
      $display("FAIL bright_spot_centroid_steer");
    end
    $finish;
  end

endmodule
